// ===== design/scx_pkg.sv =====
`default_nettype none

package scx_pkg;

   // Sample, coefficient and state widths.
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_FRAC_BITS = 16;
   localparam int COEF_BITS = 18;
   localparam int CFG_BITS = 3 * COEF_BITS;
   localparam int STATE_BITS = 40;
   localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS = ((PROD_BITS > STATE_BITS) ? PROD_BITS : STATE_BITS) + 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int NUM_FILT = 3;

   // Rounding offset of one half at the coefficient scale.
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
      ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LP1 = 2'd0,
      CSR_LP2 = 2'd1,
      CSR_HP3 = 2'd2
   } csr_index_type;

   // Order in which a lane runs its three biquads.
   typedef enum logic [1:0] {
      FILT_LP1,
      FILT_HP3,
      FILT_LP2
   } filt_type;

   // Lane sequencer states: five steps per biquad.
   typedef enum logic [2:0] {
      LANE_IDLE,
      LANE_MUL_GX,
      LANE_YOUT,
      LANE_MUL_A1,
      LANE_UPD_S1,
      LANE_UPD_S2,
      LANE_DONE
   } lane_state_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0] coef_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [STATE_BITS-1:0] state_word_type;
   typedef logic signed [ACC_BITS-1:0] acc_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] lp1;
      logic [CFG_BITS-1:0] lp2;
      logic [CFG_BITS-1:0] hp3;
   } coef_set_type;

   typedef struct packed {
      logic start;
      logic ack;
   } lane_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lane_stat_type;

   typedef struct packed {
      sample_type low;
      sample_type midlow;
      sample_type midhigh;
      sample_type high;
   } lane_result_type;

   // Sign extensions into the accumulator width.
   function automatic acc_type widen_prod(input prod_type v);
      return {{(ACC_BITS - PROD_BITS){v[PROD_BITS-1]}}, v};
   endfunction

   function automatic acc_type widen_state(input state_word_type v);
      return {{(ACC_BITS - STATE_BITS){v[STATE_BITS-1]}}, v};
   endfunction

   function automatic acc_type widen_sample(input sample_type v);
      return {{(ACC_BITS - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
   endfunction

   // Clamp to the signed sample range.
   function automatic sample_type sat_to_sample(input acc_type v);
      logic [ACC_BITS-SAMPLE_BITS:0] top_bits;
      sample_type r;
      top_bits = v[ACC_BITS-1:SAMPLE_BITS-1];
      if ((&top_bits) || !(|top_bits)) begin
         r = v[SAMPLE_BITS-1:0];
      end else if (v[ACC_BITS-1]) begin
         r = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      end else begin
         r = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      end
      return r;
   endfunction

   // Clamp to the signed state word range.
   function automatic state_word_type sat_to_state(input acc_type v);
      logic [ACC_BITS-STATE_BITS:0] top_bits;
      state_word_type r;
      top_bits = v[ACC_BITS-1:STATE_BITS-1];
      if ((&top_bits) || !(|top_bits)) begin
         r = v[STATE_BITS-1:0];
      end else if (v[ACC_BITS-1]) begin
         r = {1'b1, {(STATE_BITS - 1){1'b0}}};
      end else begin
         r = {1'b0, {(STATE_BITS - 1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/scx_lane.sv =====
`default_nettype none

module scx_lane
   import scx_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire lane_ctl_type    ctl,
   input  wire sample_type      x_in,
   input  wire coef_set_type    coefs,
   output lane_stat_type        stat,
   output lane_result_type      result
);

   lane_state_type state_ff;
   lane_state_type state_in;
   filt_type       filt_ff;
   state_word_type s1_ff [NUM_FILT];
   state_word_type s2_ff [NUM_FILT];

   sample_type x_ff;
   sample_type xin_ff;
   sample_type y_ff;
   sample_type low_ff;
   sample_type high_ff;
   sample_type midlow_ff;
   sample_type midhigh_ff;
   prod_type   gx_ff;
   prod_type   prod_ff;

   logic [CFG_BITS-1:0] coef_sel;
   coef_type   g;
   coef_type   a1;
   coef_type   a2;
   coef_type   mul_a;
   sample_type mul_b;
   prod_type   product;
   acc_type    acc_y;
   acc_type    two_gx;
   acc_type    b1x;
   sample_type y_next;
   state_word_type s1_next;
   state_word_type s2_next;
   sample_type mid_next;
   sample_type midhigh_next;

   // Coefficients of the biquad in progress.
   always_comb begin
      case (filt_ff)
         FILT_LP1: coef_sel = coefs.lp1;
         FILT_HP3: coef_sel = coefs.hp3;
         FILT_LP2: coef_sel = coefs.lp2;
         default:  coef_sel = coefs.lp1;
      endcase
   end

   assign g  = coef_sel[COEF_BITS-1:0];
   assign a1 = coef_sel[2*COEF_BITS-1:COEF_BITS];
   assign a2 = coef_sel[3*COEF_BITS-1:2*COEF_BITS];

   // Next state of the sequencer.
   always_comb begin
      case (state_ff)
         LANE_IDLE:   state_in = ctl.start ? LANE_MUL_GX : LANE_IDLE;
         LANE_MUL_GX: state_in = LANE_YOUT;
         LANE_YOUT:   state_in = LANE_MUL_A1;
         LANE_MUL_A1: state_in = LANE_UPD_S1;
         LANE_UPD_S1: state_in = LANE_UPD_S2;
         LANE_UPD_S2: state_in = (filt_ff == FILT_LP2) ? LANE_DONE : LANE_MUL_GX;
         LANE_DONE:   state_in = ctl.ack ? LANE_IDLE : LANE_DONE;
         default:     state_in = LANE_IDLE;
      endcase
   end

   // Sequencer outputs: status and multiplier operand selection.
   always_comb begin
      stat.busy = (state_ff != LANE_IDLE);
      stat.done = (state_ff == LANE_DONE);
      case (state_ff)
         LANE_MUL_A1: begin
            mul_a = a1;
            mul_b = y_ff;
         end
         LANE_UPD_S1: begin
            mul_a = a2;
            mul_b = y_ff;
         end
         default: begin
            mul_a = g;
            mul_b = x_ff;
         end
      endcase
   end

   // The one multiplier of the lane; its result is always registered.
   assign product = mul_a * mul_b;

   // Output sample: round half up, then saturate.
   assign acc_y  = widen_prod(gx_ff) + widen_state(s1_ff[filt_ff]) + ROUND_HALF;
   assign y_next = sat_to_sample(acc_y >>> COEF_FRAC_BITS);

   // State updates; b1 is twice the gain, negated for the highpass.
   assign two_gx  = widen_prod(gx_ff) <<< 1;
   assign b1x     = (filt_ff == FILT_HP3) ? -two_gx : two_gx;
   assign s1_next = sat_to_state(b1x - widen_prod(prod_ff) + widen_state(s2_ff[filt_ff]));
   assign s2_next = sat_to_state(widen_prod(gx_ff) - widen_prod(prod_ff));

   // Band differences.
   assign mid_next = sat_to_sample(widen_sample(xin_ff) - widen_sample(low_ff)
                                   - widen_sample(y_ff));
   assign midhigh_next = sat_to_sample(widen_sample(x_ff) - widen_sample(y_ff));

   // Control and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_IDLE;
         filt_ff  <= FILT_LP1;
         for (int i = 0; i < NUM_FILT; i++) begin
            s1_ff[i] <= '0;
            s2_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         case (state_ff)
            LANE_IDLE: begin
               if (ctl.start) begin
                  filt_ff <= FILT_LP1;
               end
            end
            LANE_UPD_S1: begin
               s1_ff[filt_ff] <= s1_next;
            end
            LANE_UPD_S2: begin
               s2_ff[filt_ff] <= s2_next;
               case (filt_ff)
                  FILT_LP1: filt_ff <= FILT_HP3;
                  FILT_HP3: filt_ff <= FILT_LP2;
                  default:  filt_ff <= FILT_LP2;
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         LANE_IDLE: begin
            if (ctl.start) begin
               x_ff   <= x_in;
               xin_ff <= x_in;
            end
         end
         LANE_MUL_GX: gx_ff <= product;
         LANE_YOUT:   y_ff <= y_next;
         LANE_MUL_A1: prod_ff <= product;
         LANE_UPD_S1: prod_ff <= product;
         LANE_UPD_S2: begin
            case (filt_ff)
               FILT_LP1: low_ff <= y_ff;
               FILT_HP3: begin
                  high_ff <= y_ff;
                  x_ff    <= mid_next;
               end
               default: begin
                  midlow_ff  <= y_ff;
                  midhigh_ff <= midhigh_next;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign result.low     = low_ff;
   assign result.midlow  = midlow_ff;
   assign result.midhigh = midhigh_ff;
   assign result.high    = high_ff;

endmodule

`default_nettype wire

// ===== design/stereo_four_band_crossover.sv =====
`default_nettype none

// Stereo four-band crossover. Each item is one left/right sample pair and
// gives one result item with low, mid-low, mid-high and high bands for both
// channels. Two identical lanes, one per channel, each run the low lowpass,
// the high highpass and the mid-split lowpass one after the other through
// its own single multiplier; an output register then merges both lanes
// into the result item. An item runs through the lane sequencers, then both
// finished lanes hand their bands to the output register when it is free,
// and then the input side is open again and takes the next item. A finished
// result may wait in the output register while the next item is accepted.
// Coefficient registers are written through the csr_ port and reset to
// zero. The user must write them only while the block is idle; the block
// itself does not enforce this.

module stereo_four_band_crossover
   import scx_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  wire logic signed [SAMPLE_BITS-1:0] req_right_in,

   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]  rsp_low_left,
   output logic signed [SAMPLE_BITS-1:0]  rsp_low_right,
   output logic signed [SAMPLE_BITS-1:0]  rsp_midlow_left,
   output logic signed [SAMPLE_BITS-1:0]  rsp_midlow_right,
   output logic signed [SAMPLE_BITS-1:0]  rsp_midhigh_left,
   output logic signed [SAMPLE_BITS-1:0]  rsp_midhigh_right,
   output logic signed [SAMPLE_BITS-1:0]  rsp_high_left,
   output logic signed [SAMPLE_BITS-1:0]  rsp_high_right,

   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]       csr_data
);

   coef_set_type    coefs_ff;
   logic            busy_ff;
   logic            rsp_valid_ff;
   lane_result_type left_ff;
   lane_result_type right_ff;

   lane_ctl_type    lane_ctl;
   lane_stat_type   stat_left;
   lane_stat_type   stat_right;
   lane_result_type res_left;
   lane_result_type res_right;
   logic            accept;
   logic            merge;

   // Coefficient registers; writes to unused indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LP1: coefs_ff.lp1 <= csr_data;
            CSR_LP2: coefs_ff.lp2 <= csr_data;
            CSR_HP3: coefs_ff.hp3 <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Handshake and lane control.
   assign req_ready      = !busy_ff;
   assign accept         = req_valid && req_ready;
   assign merge          = stat_left.done && stat_right.done && (!rsp_valid_ff || rsp_ready);
   assign lane_ctl.start = accept;
   assign lane_ctl.ack   = merge;

   scx_lane u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .ctl    (lane_ctl),
      .x_in   (req_left_in),
      .coefs  (coefs_ff),
      .stat   (stat_left),
      .result (res_left)
   );

   scx_lane u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .ctl    (lane_ctl),
      .x_in   (req_right_in),
      .coefs  (coefs_ff),
      .stat   (stat_right),
      .result (res_right)
   );

   // Busy from acceptance until both lanes hand over their bands.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (merge) begin
            busy_ff <= 1'b0;
         end
         if (merge) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Merge stage: output register for both lanes.
   always_ff @(posedge clock) begin
      if (merge) begin
         left_ff  <= res_left;
         right_ff <= res_right;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_low_left      = left_ff.low;
   assign rsp_low_right     = right_ff.low;
   assign rsp_midlow_left   = left_ff.midlow;
   assign rsp_midlow_right  = right_ff.midlow;
   assign rsp_midhigh_left  = left_ff.midhigh;
   assign rsp_midhigh_right = right_ff.midhigh;
   assign rsp_high_left     = left_ff.high;
   assign rsp_high_right    = right_ff.high;

`ifndef SYNTHESIS
   // Both lanes run in lockstep.
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (stat_left.done == stat_right.done) && (stat_left.busy == stat_right.busy))
      else $error("lanes out of step");

   // An accepted item starts both lanes.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (stat_left.busy && stat_right.busy))
      else $error("lanes did not start on an accepted item");

   // A new result appears only as the block frees its input side.
   a_result_frees: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> !busy_ff)
      else $error("result shown while still busy");

   // A finished lane waits while the output register is stalled.
   a_lane_waits: assert property (@(posedge clock) disable iff (reset)
      (stat_left.done && rsp_valid_ff && !rsp_ready) |=> stat_left.done)
      else $error("lane left its done state during a stall");
`endif

endmodule

`default_nettype wire

// ===== test/tb_stereo_four_band_crossover.sv =====
module tb_stereo_four_band_crossover;
   import scx_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 144;
   localparam int NUM_WORDS = 12;
   localparam longint TIMEOUT_UNITS = 64'd7200000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
   localparam longint COEF_MAX = (longint'(1) <<< (COEF_BITS - 1)) - 1;
   localparam longint COEF_MIN = -(longint'(1) <<< (COEF_BITS - 1));

   typedef enum int {
      COEF_DESIGNED,
      COEF_RAW,
      COEF_EXTREME
   } coef_style_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } stereo_pair_type;

   typedef struct packed {
      sample_type low_left;
      sample_type low_right;
      sample_type midlow_left;
      sample_type midlow_right;
      sample_type midhigh_left;
      sample_type midhigh_right;
      sample_type high_left;
      sample_type high_right;
   } band_set_type;

   // Block ports.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   sample_type req_left_in = '0;
   sample_type req_right_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   sample_type rsp_low_left, rsp_low_right;
   sample_type rsp_midlow_left, rsp_midlow_right;
   sample_type rsp_midhigh_left, rsp_midhigh_right;
   sample_type rsp_high_left, rsp_high_right;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0] csr_data = '0;

   // Predictor copy of the filter state and the coefficient registers.
   longint filter_words [NUM_WORDS];
   logic [CFG_BITS-1:0] coef_regs [NUM_FILT];

   stereo_pair_type pending_pairs [$];
   band_set_type expected_bands [$];
   stereo_pair_type next_pair;
   band_set_type due_bands;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int pairs_queued = 0;
   int pairs_accepted = 0;
   int results_checked = 0;
   int coef_writes = 0;
   int error_count = 0;

   stereo_four_band_crossover dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_left_in      (req_left_in),
      .req_right_in     (req_right_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_low_left     (rsp_low_left),
      .rsp_low_right    (rsp_low_right),
      .rsp_midlow_left  (rsp_midlow_left),
      .rsp_midlow_right (rsp_midlow_right),
      .rsp_midhigh_left (rsp_midhigh_left),
      .rsp_midhigh_right(rsp_midhigh_right),
      .rsp_high_left    (rsp_high_left),
      .rsp_high_right   (rsp_high_right),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Clamp a value to a signed range of the given width.
   function automatic longint clamp_signed(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Signed coefficient field pos (0 gain, 1 a1, 2 a2) of a register.
   function automatic longint coef_field(input logic [CFG_BITS-1:0] reg_value, input int pos);
      coef_type c;
      c = reg_value[pos * COEF_BITS +: COEF_BITS];
      return longint'(c);
   endfunction

   // One transposed direct form II biquad step on state words slot, slot+1.
   function automatic longint run_biquad(input int slot, input logic [CFG_BITS-1:0] coefs,
                                         input bit highpass, input longint x);
      longint g, a1, a2, b1, acc, y;
      g = coef_field(coefs, 0);
      a1 = coef_field(coefs, 1);
      a2 = coef_field(coefs, 2);
      b1 = highpass ? -2 * g : 2 * g;
      acc = g * x + filter_words[slot];
      y = clamp_signed((acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS,
                       SAMPLE_BITS);
      filter_words[slot] = clamp_signed(b1 * x - a1 * y + filter_words[slot + 1], STATE_BITS);
      filter_words[slot + 1] = clamp_signed(g * x - a2 * y, STATE_BITS);
      return y;
   endfunction

   // Expected bands of one stereo pair; advances the predictor state.
   function automatic band_set_type split_bands(input sample_type left, input sample_type right);
      band_set_type bands;
      longint x, lo, hi, mid, ml, mh;
      int base;
      for (int ch = 0; ch < 2; ch++) begin
         base = ch * 6;
         if (ch == 0) begin
            x = longint'(left);
         end else begin
            x = longint'(right);
         end
         lo = run_biquad(base, coef_regs[CSR_LP1], 1'b0, x);
         hi = run_biquad(base + 2, coef_regs[CSR_HP3], 1'b1, x);
         mid = clamp_signed(x - lo - hi, SAMPLE_BITS);
         ml = run_biquad(base + 4, coef_regs[CSR_LP2], 1'b0, mid);
         mh = clamp_signed(mid - ml, SAMPLE_BITS);
         if (ch == 0) begin
            bands.low_left = lo[SAMPLE_BITS-1:0];
            bands.midlow_left = ml[SAMPLE_BITS-1:0];
            bands.midhigh_left = mh[SAMPLE_BITS-1:0];
            bands.high_left = hi[SAMPLE_BITS-1:0];
         end else begin
            bands.low_right = lo[SAMPLE_BITS-1:0];
            bands.midlow_right = ml[SAMPLE_BITS-1:0];
            bands.midhigh_right = mh[SAMPLE_BITS-1:0];
            bands.high_right = hi[SAMPLE_BITS-1:0];
         end
      end
      return bands;
   endfunction

   // Pack gain, a1 and a2 into one register value.
   function automatic logic [CFG_BITS-1:0] pack_coefs(input longint g, input longint a1,
                                                      input longint a2);
      coef_type gq, a1q, a2q;
      gq = coef_type'(clamp_signed(g, COEF_BITS));
      a1q = coef_type'(clamp_signed(a1, COEF_BITS));
      a2q = coef_type'(clamp_signed(a2, COEF_BITS));
      return {a2q, a1q, gq};
   endfunction

   // Round a real coefficient to the fixed-point scale.
   function automatic longint quantize(input real v);
      real scaled;
      scaled = v * real'(longint'(1) <<< COEF_FRAC_BITS);
      return clamp_signed(longint'($rtoi(scaled + ((v < 0.0) ? -0.5 : 0.5))), COEF_BITS);
   endfunction

   // Second-order section at a random crossover frequency and Q, 48 kHz rate.
   function automatic logic [CFG_BITS-1:0] designed_coefs(input bit highpass);
      real w, cw, alpha, a0, q, b0;
      w = 2.0 * 3.14159265358979 * real'($urandom_range(18000, 20)) / 48000.0;
      q = 0.5 + real'($urandom_range(100)) / 100.0;
      cw = $cos(w);
      alpha = $sin(w) / (2.0 * q);
      a0 = 1.0 + alpha;
      b0 = (highpass ? (1.0 + cw) : (1.0 - cw)) / (2.0 * a0);
      return pack_coefs(quantize(b0), quantize(-2.0 * cw / a0), quantize((1.0 - alpha) / a0));
   endfunction

   function automatic logic [CFG_BITS-1:0] pick_coefs(input coef_style_type style,
                                                      input bit highpass);
      logic [CFG_BITS-1:0] value;
      case (style)
         COEF_DESIGNED: value = designed_coefs(highpass);
         COEF_RAW: value = CFG_BITS'({$urandom, $urandom});
         default: begin
            case ($urandom_range(3))
               0: value = '0;
               1: value = '1;
               2: value = pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX);
               default: value = pack_coefs(COEF_MIN, COEF_MIN, COEF_MIN);
            endcase
         end
      endcase
      return value;
   endfunction

   // Mostly full-range samples, some quiet ones and some at the rails.
   function automatic sample_type random_sample();
      int pick;
      int v;
      pick = $urandom_range(19);
      if (pick < 12) return sample_type'($urandom);
      if (pick < 17) begin
         v = $urandom_range(8191) - 4096;
         return sample_type'(v);
      end
      if (pick == 17) return SAMPLE_MAX;
      if (pick == 18) return SAMPLE_MIN;
      return sample_type'(-1);
   endfunction

   task automatic queue_pair(input sample_type left, input sample_type right);
      pending_pairs.push_back('{left: left, right: right});
      pairs_queued++;
   endtask

   // Sender and receiver idle rates for one phase.
   task automatic set_idle(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 59;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            recv_stall_pct = 59;
         end
         default: begin
            send_idle_pct = 25;
            recv_stall_pct = 25;
         end
      endcase
   endtask

   // Write one coefficient register; only called while the block is idle.
   task automatic write_coefs(input logic [CSR_INDEX_BITS-1:0] index,
                              input logic [CFG_BITS-1:0] value);
      @(posedge clock);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      coef_writes++;
      if (index < NUM_FILT) coef_regs[index] = value;
   endtask

   // Wait until every queued item has been accepted and answered.
   task automatic wait_drained();
      while (pairs_accepted < pairs_queued || expected_bands.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_band(input string name, input sample_type want, input sample_type got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Driver: presents pending items and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_bands.push_back(split_bands(req_left_in, req_right_in));
            pairs_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_pair = pending_pairs.pop_front();
               req_left_in <= next_pair.left;
               req_right_in <= next_pair.right;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted result item with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bands.size() == 0) begin
               $display("%0t: result item arrived with no expected bands pending", $time);
               error_count++;
            end else begin
               due_bands = expected_bands.pop_front();
               check_band("low_left", due_bands.low_left, rsp_low_left);
               check_band("low_right", due_bands.low_right, rsp_low_right);
               check_band("midlow_left", due_bands.midlow_left, rsp_midlow_left);
               check_band("midlow_right", due_bands.midlow_right, rsp_midlow_right);
               check_band("midhigh_left", due_bands.midhigh_left, rsp_midhigh_left);
               check_band("midhigh_right", due_bands.midhigh_right, rsp_midhigh_right);
               check_band("high_left", due_bands.high_left, rsp_high_left);
               check_band("high_right", due_bands.high_right, rsp_high_right);
               results_checked++;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Stimulus sequence.
   initial begin
      coef_style_type style;
      for (int i = 0; i < NUM_WORDS; i++) filter_words[i] = 0;
      for (int i = 0; i < NUM_FILT; i++) coef_regs[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Zero coefficients from reset: low, high and mid-low are silent, mid-high passes through.
      set_idle(0);
      queue_pair(SAMPLE_MAX, SAMPLE_MIN);
      queue_pair(SAMPLE_MIN, SAMPLE_MAX);
      queue_pair(sample_type'(0), sample_type'(-1));
      queue_pair(sample_type'(-1), sample_type'(0));
      wait_drained();

      // A write to an unused index must leave every register unchanged.
      write_coefs(CSR_UNUSED, '1);
      queue_pair(SAMPLE_MAX, SAMPLE_MAX);
      queue_pair(SAMPLE_MIN, 24'sd12345);
      wait_drained();

      // All ones in every register.
      write_coefs(CSR_LP1, '1);
      write_coefs(CSR_LP2, '1);
      write_coefs(CSR_HP3, '1);
      queue_pair(SAMPLE_MAX, SAMPLE_MIN);
      queue_pair(24'sd65536, -24'sd65536);
      queue_pair(SAMPLE_MIN, SAMPLE_MAX);
      wait_drained();

      // Gains at the rails so that the band sums overflow and saturate.
      write_coefs(CSR_LP1, pack_coefs(COEF_MAX, 0, 0));
      write_coefs(CSR_HP3, pack_coefs(COEF_MAX, 0, 0));
      write_coefs(CSR_LP2, pack_coefs(COEF_MIN, 0, 0));
      queue_pair(SAMPLE_MAX, SAMPLE_MAX);
      queue_pair(SAMPLE_MIN, SAMPLE_MIN);
      queue_pair(SAMPLE_MAX, SAMPLE_MIN);
      queue_pair(SAMPLE_MIN, SAMPLE_MAX);
      wait_drained();

      // Unstable feedback drives the state words into saturation.
      set_idle(3);
      write_coefs(CSR_LP1, pack_coefs(COEF_MAX, COEF_MIN, COEF_MAX));
      write_coefs(CSR_HP3, pack_coefs(COEF_MIN, COEF_MAX, COEF_MAX));
      write_coefs(CSR_LP2, pack_coefs(COEF_MAX, COEF_MIN, COEF_MIN));
      for (int i = 0; i < 8; i++) begin
         if (i[0]) begin
            queue_pair(SAMPLE_MIN, SAMPLE_MAX);
         end else begin
            queue_pair(random_sample(), random_sample());
         end
      end
      wait_drained();

      // Random phases: new coefficients each time, idle modes in rotation.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 2 || phase == 6) begin
            style = COEF_RAW;
         end else if (phase == 4) begin
            style = COEF_EXTREME;
         end else begin
            style = COEF_DESIGNED;
         end
         set_idle(phase % 4);
         write_coefs(CSR_LP1, pick_coefs(style, 1'b0));
         write_coefs(CSR_LP2, pick_coefs(style, 1'b0));
         write_coefs(CSR_HP3, pick_coefs(style, 1'b1));
         repeat (PHASE_ITEMS) queue_pair(random_sample(), random_sample());
         wait_drained();
      end

      $display("Checked %0d result items from %0d stereo pairs over %0d coefficient writes,",
               results_checked, pairs_accepted, coef_writes);
      $display("with designed, raw and rail coefficients under four idle and stall patterns.");
      if (error_count == 0) begin
         $display("tb_stereo_four_band_crossover: done, clean");
      end else begin
         $display("tb_stereo_four_band_crossover: done, errors");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_UNITS);
      $display("Timeout with %0d items pending and %0d results outstanding.",
               pending_pairs.size(), expected_bands.size());
      $display("tb_stereo_four_band_crossover: done, errors");
      $finish;
   end

endmodule
